// ===== rtl/access_list_table_engine_assert.svh =====
// Assertion macros for the access list table engine
`ifndef ACCESS_LIST_TABLE_ENGINE_ASSERT_SVH
`define ACCESS_LIST_TABLE_ENGINE_ASSERT_SVH
`ifndef SYNTH
`define ALTE_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant violated");
`define ALTE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequence violated");
`else
`define ALTE_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ALTE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/alte_pkg.sv =====
`default_nettype none
package alte_pkg;
   localparam int DEPTH   = 32;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = IDX_W + 1;
   localparam int KEY_W   = 256;
   localparam int PERM_W  = 8;
   localparam int ACT_W   = 32;
   localparam int KEY_BYTES = KEY_W / 8;

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_APPLY  = 2'd1;
   localparam logic [1:0] CMD_TOUCH  = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   localparam logic [7:0] REG_ROLE_MASK  = 8'd0;
   localparam logic [7:0] REG_GUEST_CODE = 8'd1;
   localparam logic [7:0] REG_ADMIN_CODE = 8'd2;

   localparam logic [ACT_W-1:0] ACT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [PERM_W-1:0] perm;
      logic [ACT_W-1:0]  act;
   } entry_type;

   typedef struct packed {
      logic hit;
      logic admin;
      logic less;
   } match_type;
endpackage
`default_nettype wire

// ===== rtl/alte_ram.sv =====
`default_nettype none
module alte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== rtl/alte_match.sv =====
`default_nettype none
module alte_match (
   input  wire alte_pkg::entry_type                ent,
   input  wire logic [alte_pkg::KEY_W-1:0]         key,
   input  wire logic [alte_pkg::KEY_W-1:0]         mask,
   input  wire logic [7:0]                         role_mask,
   input  wire logic [7:0]                         admin_code,
   input  wire logic [alte_pkg::ACT_W-1:0]         least,
   output alte_pkg::match_type                     res
);
   always_comb begin
      res.hit   = ((ent.key ^ key) & mask) == '0;
      res.admin = (ent.perm & role_mask) == admin_code;
      res.less  = ent.act < least;
   end
endmodule
`default_nettype wire

// ===== rtl/access_list_table_engine.sv =====
`default_nettype none
// Access list table engine: a 32-entry key table held in one synchronous RAM.
// Requests enter on req_valid/req_ready with a command, a 256-bit key in four
// words, a key length in bytes, a permission byte and an activity time. Each
// request yields exactly one response on rsp_valid/rsp_ready: hit, slot,
// permission byte and the entry count after the command.
// One request is worked at a time. Lookup, touch and apply walk the stored
// entries in slot order, one RAM read a cycle; a guest removal stops the walk
// at its match and then shifts the entries above it down, one per cycle.
// Clear and a rejected short-key insert skip the walk.
// Registers are written on csr_valid/csr_ready, always ready; indexes above 2
// are ignored. Reset empties the table and loads the register defaults; the
// RAM itself is not cleared. A stalled response holds in the output register
// and the engine waits for it before finishing the next request.
module access_list_table_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [63:0] req_key_word0,
   input  wire logic [63:0] req_key_word1,
   input  wire logic [63:0] req_key_word2,
   input  wire logic [63:0] req_key_word3,
   input  wire logic [5:0]  req_key_length,
   input  wire logic [7:0]  req_new_perms,
   input  wire logic [31:0] req_activity_time,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_hit,
   output logic [4:0]       rsp_slot,
   output logic [7:0]       rsp_perms_out,
   output logic [5:0]       rsp_entry_count,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);
   localparam int IDX_W = alte_pkg::IDX_W;
   localparam int CNT_W = alte_pkg::CNT_W;
   localparam int KEY_W = alte_pkg::KEY_W;
   localparam int ACT_W_C = alte_pkg::ACT_W;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [7:0] role_mask_ff, guest_code_ff, admin_code_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] lim_ff, lim_in;
   logic rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [ACT_W_C-1:0] least_ff, least_in;
   logic [IDX_W-1:0] victim_ff, victim_in;

   // request registers (payload, no reset)
   logic [1:0] cmd_ff, cmd_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [KEY_W-1:0] mask_ff, mask_in;
   logic [7:0] perms_ff, perms_in;
   logic [alte_pkg::ACT_W-1:0] act_ff, act_in;
   logic guest_ff, guest_in;

   logic res_hit_ff, res_hit_in;
   logic [IDX_W-1:0] res_slot_ff, res_slot_in;
   logic [7:0] res_perm_ff, res_perm_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_hit_ff;
   logic [4:0] rsp_slot_ff;
   logic [7:0] rsp_perm_ff;
   logic [5:0] rsp_count_ff;

   logic ram_we;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   alte_pkg::entry_type ram_wdata, ram_rdata;
   alte_pkg::match_type mres;

   logic [5:0] len_c;
   logic [8:0] shamt;
   logic full_key;
   logic req_fire;

   alte_ram #(.WIDTH($bits(alte_pkg::entry_type)), .DEPTH(alte_pkg::DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   alte_match u_match (
      .ent        (ram_rdata),
      .key        (key_ff),
      .mask       (mask_ff),
      .role_mask  (role_mask_ff),
      .admin_code (admin_code_ff),
      .least      (least_ff),
      .res        (mres)
   );

   assign req_ready = state_ff == S_IDLE;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit = rsp_hit_ff;
   assign rsp_slot = rsp_slot_ff;
   assign rsp_perms_out = rsp_perm_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign full_key = mask_ff == '1;

   always_comb begin
      len_c = (req_key_length > 6'(alte_pkg::KEY_BYTES)) ? 6'(alte_pkg::KEY_BYTES)
                                                         : req_key_length;
      shamt = (9'(alte_pkg::KEY_BYTES) - {3'b000, len_c}) << 3;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ptr_in = ptr_ff;
      lim_in = lim_ff;
      rd_valid_in = 1'b0;
      rd_idx_in = rd_idx_ff;
      least_in = least_ff;
      victim_in = victim_ff;
      cmd_in = cmd_ff;
      key_in = key_ff;
      mask_in = mask_ff;
      perms_in = perms_ff;
      act_in = act_ff;
      guest_in = guest_ff;
      res_hit_in = res_hit_ff;
      res_slot_in = res_slot_ff;
      res_perm_in = res_perm_ff;
      ram_we = 1'b0;
      ram_waddr = rd_idx_ff;
      ram_wdata = ram_rdata;
      ram_raddr = ptr_ff[IDX_W-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in = req_cmd;
               key_in = {req_key_word0, req_key_word1, req_key_word2, req_key_word3};
               mask_in = {KEY_W{1'b1}} << shamt;
               perms_in = req_new_perms;
               act_in = req_activity_time;
               guest_in = (req_new_perms & role_mask_ff) == guest_code_ff;
               res_hit_in = 1'b0;
               res_slot_in = '0;
               res_perm_in = '0;
               ptr_in = '0;
               least_in = alte_pkg::ACT_MAX;
               victim_in = IDX_W'(alte_pkg::DEPTH - 1);
               if (req_cmd == alte_pkg::CMD_CLEAR) begin
                  count_in = '0;
                  res_hit_in = 1'b1;
                  state_in = S_DONE;
               end else if (req_cmd == alte_pkg::CMD_APPLY &&
                            (req_new_perms & role_mask_ff) != guest_code_ff &&
                            len_c != 6'(alte_pkg::KEY_BYTES)) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (ptr_ff < count_ff) begin
               rd_valid_in = 1'b1;
               rd_idx_in = ptr_ff[IDX_W-1:0];
               ptr_in = ptr_ff + 1'b1;
            end
            if (rd_valid_ff && mres.hit) begin
               rd_valid_in = 1'b0;
               res_hit_in = 1'b1;
               res_slot_in = rd_idx_ff;
               res_perm_in = ram_rdata.perm;
               state_in = S_DONE;
               if (cmd_ff == alte_pkg::CMD_TOUCH) begin
                  ram_we = 1'b1;
                  ram_wdata.act = act_ff;
               end else if (cmd_ff == alte_pkg::CMD_APPLY) begin
                  if (guest_ff) begin
                     res_perm_in = '0;
                     count_in = count_ff - 1'b1;
                     lim_in = count_ff;
                     ptr_in = {1'b0, rd_idx_ff} + 1'b1;
                     state_in = S_SHIFT;
                  end else begin
                     ram_we = 1'b1;
                     ram_wdata.perm = perms_ff;
                     res_perm_in = perms_ff;
                  end
               end
            end else begin
               if (rd_valid_ff && !mres.admin && mres.less) begin
                  least_in = ram_rdata.act;
                  victim_in = rd_idx_ff;
               end
               if (ptr_ff >= count_ff) begin
                  // walked every entry without a match
                  rd_valid_in = 1'b0;
                  state_in = S_DONE;
                  if (cmd_ff == alte_pkg::CMD_APPLY && !guest_ff && full_key) begin
                     ram_we = 1'b1;
                     ram_wdata.key = key_ff;
                     ram_wdata.perm = perms_ff;
                     ram_wdata.act = '0;
                     res_hit_in = 1'b1;
                     res_perm_in = perms_ff;
                     if (count_ff < CNT_W'(alte_pkg::DEPTH)) begin
                        ram_waddr = count_ff[IDX_W-1:0];
                        res_slot_in = count_ff[IDX_W-1:0];
                        count_in = count_ff + 1'b1;
                     end else begin
                        // full: evict the chosen victim, or the entry read in this
                        // cycle if it beats the running least
                        ram_waddr = (rd_valid_ff && !mres.admin && mres.less)
                                    ? rd_idx_ff : victim_ff;
                        res_slot_in = ram_waddr;
                     end
                  end
               end
            end
         end
         S_SHIFT: begin
            // read entry i+1, write it to i the cycle after
            if (ptr_ff < lim_ff) begin
               rd_valid_in = 1'b1;
               rd_idx_in = ptr_ff[IDX_W-1:0];
               ptr_in = ptr_ff + 1'b1;
            end
            if (rd_valid_ff) begin
               ram_we = 1'b1;
               ram_waddr = rd_idx_ff - 1'b1;
            end
            if (ptr_ff >= lim_ff && !rd_valid_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         role_mask_ff <= 8'd3;
         guest_code_ff <= 8'd0;
         admin_code_ff <= 8'd3;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rd_valid_ff <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               alte_pkg::REG_ROLE_MASK:  role_mask_ff <= csr_wdata;
               alte_pkg::REG_GUEST_CODE: guest_code_ff <= csr_wdata;
               alte_pkg::REG_ADMIN_CODE: admin_code_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      lim_ff <= lim_in;
      rd_idx_ff <= rd_idx_in;
      least_ff <= least_in;
      victim_ff <= victim_in;
      cmd_ff <= cmd_in;
      key_ff <= key_in;
      mask_ff <= mask_in;
      perms_ff <= perms_in;
      act_ff <= act_in;
      guest_ff <= guest_in;
      res_hit_ff <= res_hit_in;
      res_slot_ff <= res_slot_in;
      res_perm_ff <= res_perm_in;
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_hit_ff <= res_hit_ff;
         rsp_slot_ff <= 5'(res_slot_ff);
         rsp_perm_ff <= res_perm_ff;
         rsp_count_ff <= 6'(count_ff);
      end
   end

`include "access_list_table_engine_assert.svh"
   `ALTE_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CNT_W'(alte_pkg::DEPTH))
   `ALTE_ASSERT_ALWAYS(a_write_busy, clock, reset, !ram_we || state_ff != S_IDLE)
   `ALTE_ASSERT_NEXT(a_accept_busy, clock, reset, req_fire, state_ff != S_IDLE)
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none
module tb_top;
   localparam logic [7:0] REG_UNMAPPED = 8'd200;
   localparam int POOL_SIZE = 48;

   typedef struct packed {
      logic       hit;
      logic [4:0] slot;
      logic [7:0] perms;
      logic [5:0] count;
   } acl_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = alte_pkg::CMD_LOOKUP;
   logic [63:0] req_key_word0 = '0;
   logic [63:0] req_key_word1 = '0;
   logic [63:0] req_key_word2 = '0;
   logic [63:0] req_key_word3 = '0;
   logic [5:0]  req_key_length = '0;
   logic [7:0]  req_new_perms = '0;
   logic [31:0] req_activity_time = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_hit;
   logic [4:0]  rsp_slot;
   logic [7:0]  rsp_perms_out;
   logic [5:0]  rsp_entry_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   // shadow table and registers
   logic [alte_pkg::KEY_W-1:0] key_tab [alte_pkg::DEPTH];
   logic [7:0]       perm_tab [alte_pkg::DEPTH];
   logic [31:0]      act_tab [alte_pkg::DEPTH];
   int               tab_count;
   logic [7:0]       role_mask, guest_code, admin_code;

   acl_result_type   pending_results [$];
   logic [alte_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
   int               error_count = 0;
   int               burst_left = 0;
   int               hold_cycles = 0;
   int               stall_mode = 0;
   int               mode_left = 0;

   access_list_table_engine DUT (.*);

   always #6 clock = ~clock;

   initial begin
      #(12 * 3000000);
      $display("Verification failed");
      $finish;
   end

   function automatic logic prefix_hit(int e, logic [alte_pkg::KEY_W-1:0] k, int len);
      logic [alte_pkg::KEY_W-1:0] mask;
      mask = (len == 0) ? '0 : ~('1 >> (8 * len));
      return ((key_tab[e] ^ k) & mask) == '0;
   endfunction

   function automatic int first_prefix(logic [alte_pkg::KEY_W-1:0] k, int len);
      for (int i = 0; i < tab_count; i++)
         if (prefix_hit(i, k, len)) return i;
      return -1;
   endfunction

   task automatic predict_access(logic [1:0] cmd, logic [alte_pkg::KEY_W-1:0] k,
                                 logic [5:0] len_in, logic [7:0] perms, logic [31:0] act);
      acl_result_type r;
      int len, f, victim, i;
      logic [31:0] least;
      logic found;
      r = '0;
      len = (len_in > alte_pkg::KEY_BYTES) ? alte_pkg::KEY_BYTES : len_in;
      case (cmd)
         alte_pkg::CMD_LOOKUP, alte_pkg::CMD_TOUCH: begin
            f = first_prefix(k, len);
            if (f >= 0) begin
               if (cmd == alte_pkg::CMD_TOUCH) act_tab[f] = act;
               r.hit = 1'b1;
               r.slot = f[4:0];
               r.perms = perm_tab[f];
            end
         end
         alte_pkg::CMD_APPLY: begin
            if ((perms & role_mask) == guest_code) begin
               f = first_prefix(k, len);
               if (f >= 0) begin
                  tab_count--;
                  for (i = f; i < tab_count; i++) begin
                     key_tab[i] = key_tab[i+1];
                     perm_tab[i] = perm_tab[i+1];
                     act_tab[i] = act_tab[i+1];
                  end
                  r.hit = 1'b1;
                  r.slot = f[4:0];
               end
            end else if (len >= alte_pkg::KEY_BYTES) begin
               victim = alte_pkg::DEPTH - 1;
               least = alte_pkg::ACT_MAX;
               found = 1'b0;
               for (i = 0; i < tab_count; i++) begin
                  if (prefix_hit(i, k, alte_pkg::KEY_BYTES)) begin
                     found = 1'b1;
                     break;
                  end
                  if ((perm_tab[i] & role_mask) != admin_code && act_tab[i] < least) begin
                     victim = i;
                     least = act_tab[i];
                  end
               end
               if (!found) begin
                  if (tab_count < alte_pkg::DEPTH) begin
                     i = tab_count;
                     tab_count++;
                  end else begin
                     i = victim;
                  end
                  key_tab[i] = k;
                  act_tab[i] = '0;
               end
               perm_tab[i] = perms;
               r.hit = 1'b1;
               r.slot = i[4:0];
               r.perms = perms;
            end
         end
         default: begin
            tab_count = 0;
            r.hit = 1'b1;
         end
      endcase
      r.count = tab_count[5:0];
      pending_results.push_back(r);
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      acl_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response", rsp_slot, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_hit !== want.hit) report_mismatch("hit", rsp_hit, want.hit);
            if (rsp_slot !== want.slot) report_mismatch("slot", rsp_slot, want.slot);
            if (rsp_perms_out !== want.perms)
               report_mismatch("perms_out", rsp_perms_out, want.perms);
            if (rsp_entry_count !== want.count)
               report_mismatch("entry_count", rsp_entry_count, want.count);
         end
      end
   end

   // response stall pattern, plus a long hold-off on demand
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(20, 120);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 0);
            2: rsp_ready <= ($urandom_range(0, 4) == 0);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // caller is at a rising edge; returns after the request is taken
   task automatic send_request(logic [1:0] cmd, logic [alte_pkg::KEY_W-1:0] k,
                               logic [5:0] len, logic [7:0] perms, logic [31:0] act);
      int gap;
      req_valid <= 1'b1;
      req_cmd <= cmd;
      {req_key_word0, req_key_word1, req_key_word2, req_key_word3} <= k;
      req_key_length <= len;
      req_new_perms <= perms;
      req_activity_time <= act;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_access(cmd, k, len, perms, act);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [7:0] idx, logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         alte_pkg::REG_ROLE_MASK: role_mask = value;
         alte_pkg::REG_GUEST_CODE: guest_code = value;
         alte_pkg::REG_ADMIN_CODE: admin_code = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_roles(logic [7:0] mask, logic [7:0] guest, logic [7:0] admin);
      wait_idle();
      write_csr(alte_pkg::REG_ROLE_MASK, mask);
      write_csr(alte_pkg::REG_GUEST_CODE, guest);
      write_csr(alte_pkg::REG_ADMIN_CODE, admin);
   endtask

   function automatic logic [alte_pkg::KEY_W-1:0] random_key();
      logic [alte_pkg::KEY_W-1:0] k;
      for (int i = 0; i < 8; i++) k[32*i +: 32] = $urandom;
      return k;
   endfunction

   task automatic random_request();
      logic [alte_pkg::KEY_W-1:0] k;
      logic [7:0] perms;
      logic [5:0] len;
      int pick;
      k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if ($urandom_range(0, 9) == 0) k = random_key();
      len = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'd32;
      perms = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         send_request(alte_pkg::CMD_APPLY, k, len, perms, $urandom);
      end else if (pick < 55) begin
         // removal: force the role bits to the guest code
         perms = (perms & ~role_mask) | (guest_code & role_mask);
         send_request(alte_pkg::CMD_APPLY, k, 6'($urandom_range(0, 63)), perms, $urandom);
      end else if (pick < 75) begin
         send_request(alte_pkg::CMD_LOOKUP, k, 6'($urandom_range(0, 63)), perms, $urandom);
      end else if (pick < 98) begin
         send_request(alte_pkg::CMD_TOUCH, k, len, perms,
                      ($urandom_range(0, 5) == 0) ? alte_pkg::ACT_MAX : 32'($urandom));
      end else begin
         send_request(alte_pkg::CMD_CLEAR, k, len, perms, $urandom);
      end
   endtask

   task automatic test_directed();
      logic [alte_pkg::KEY_W-1:0] k;
      k = key_pool[0];
      send_request(alte_pkg::CMD_LOOKUP, k, 6'd32, 8'h00, 32'h0);
      send_request(alte_pkg::CMD_APPLY, k, 6'd32, 8'h01, 32'h0);
      send_request(alte_pkg::CMD_APPLY, key_pool[1], 6'd31, 8'h02, 32'h0);
      send_request(alte_pkg::CMD_APPLY, '1, 6'd32, 8'hFF, 32'h0);
      send_request(alte_pkg::CMD_APPLY, '0, 6'd63, 8'hFE, 32'h0);
      send_request(alte_pkg::CMD_LOOKUP, key_pool[5], 6'd0, 8'h00, 32'h0);
      send_request(alte_pkg::CMD_LOOKUP, '1, 6'd40, 8'h00, 32'h0);
      send_request(alte_pkg::CMD_LOOKUP, {k[255:248], ~k[247:0]}, 6'd1, 8'h00, 32'h0);
      send_request(alte_pkg::CMD_TOUCH, k, 6'd32, 8'h00, alte_pkg::ACT_MAX);
      send_request(alte_pkg::CMD_TOUCH, '0, 6'd32, 8'h00, 32'h1234_5678);
      send_request(alte_pkg::CMD_TOUCH, key_pool[7], 6'd32, 8'h00, 32'h0);
      send_request(alte_pkg::CMD_APPLY, k, 6'd32, 8'h02, 32'h0);
      send_request(alte_pkg::CMD_LOOKUP, k, 6'd32, 8'h00, 32'h0);
      send_request(alte_pkg::CMD_APPLY, key_pool[9], 6'd32, 8'h00, 32'h0);
      send_request(alte_pkg::CMD_APPLY, '1, 6'd32, 8'hFC, 32'h0);
      send_request(alte_pkg::CMD_APPLY, k, 6'd32, 8'h00, 32'h0);
      send_request(alte_pkg::CMD_LOOKUP, '0, 6'd32, 8'h00, 32'h0);
      send_request(alte_pkg::CMD_CLEAR, k, 6'd32, 8'h00, 32'h0);
      send_request(alte_pkg::CMD_LOOKUP, '0, 6'd0, 8'h00, 32'h0);
      wait_idle();
      write_csr(REG_UNMAPPED, 8'hA5);
   endtask

   task automatic test_random_roles(int n);
      repeat (n) random_request();
   endtask

   task automatic test_backpressure();
      wait_idle();
      hold_cycles = 400;
      repeat (40) random_request();
   endtask

   initial begin
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = random_key();
         // share prefixes of various lengths
         if (i >= 8 && i % 2 == 0)
            key_pool[i][255 -: 128] = key_pool[i % 8][255 -: 128];
         if (i >= 8 && i % 3 == 0)
            key_pool[i][255 -: 8] = key_pool[1][255 -: 8];
      end
      role_mask = 8'd3;
      guest_code = 8'd0;
      admin_code = 8'd3;
      tab_count = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_roles(200);
      test_backpressure();
      set_roles(8'hFF, 8'hFF, 8'h00);
      test_random_roles(150);
      set_roles(8'h00, 8'h00, 8'h00);
      test_random_roles(60);
      set_roles(8'h0C, 8'h04, 8'h08);
      test_random_roles(150);
      set_roles(8'h03, 8'h00, 8'h03);
      test_random_roles(150);
      wait_idle();
      repeat (60) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/alte_pkg.sv
rtl/alte_ram.sv
rtl/alte_match.sv
rtl/access_list_table_engine.sv
tb/sv/tb_top.sv
